// ===== sv/sfv_pkg.sv =====
// ----------------------------------------------------------------------------
// sfv_pkg
// Shared types and constants for the folded SHA-1 vertex hash pipeline.
// ----------------------------------------------------------------------------
package sfv_pkg;

    typedef logic [31:0] t_word;

    // Working variables of one round
    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_state;

    localparam int SCHED_WORDS = 16;
    localparam int NUM_ROUNDS  = 80;

    // Sliding message schedule window, element 0 is the word used this round
    typedef t_word [SCHED_WORDS-1:0] t_sched;

    localparam t_word IV0 = 32'h67452301;
    localparam t_word IV1 = 32'hEFCDAB89;
    localparam t_word IV2 = 32'h98BADCFE;
    localparam t_word IV3 = 32'h10325476;
    localparam t_word IV4 = 32'hC3D2E1F0;

    localparam t_word K_CH  = 32'h5A827999;
    localparam t_word K_PAR = 32'h6ED9EBA1;
    localparam t_word K_MAJ = 32'h8F1BBCDC;
    localparam t_word K_XOR = 32'hCA62C1D6;

    localparam t_word PAD_WORD     = 32'h00000080;
    localparam t_word VERTEX_BYTES = 32'd32;

    localparam int FOLD_SHIFT = 15;

endpackage

// ===== sv/sfv_round.sv =====
// ----------------------------------------------------------------------------
// sfv_round
// One SHA-1 round stage: registers the updated working variables and the
// message schedule window shifted by one word.
// ----------------------------------------------------------------------------
module sfv_round
    import sfv_pkg::*;
#(
    parameter int ROUND_IDX = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_state i_state,
    input  t_sched i_sched,
    output logic   o_valid,
    output t_state o_state,
    output t_sched o_sched
);

    localparam int PHASE = ROUND_IDX / 20;

    logic   r_valid;
    t_state r_state;
    t_sched r_sched;
    t_state n_state;
    t_sched n_sched;
    t_word  w_f;
    t_word  w_k;
    t_word  w_mix;

    always_comb begin
        case (PHASE)
            0: begin
                w_f = (i_state.b & i_state.c) | (~i_state.b & i_state.d);
                w_k = K_CH;
            end
            1: begin
                w_f = i_state.b ^ i_state.c ^ i_state.d;
                w_k = K_PAR;
            end
            2: begin
                w_f = (i_state.b & i_state.c) | (i_state.b & i_state.d)
                    | (i_state.c & i_state.d);
                w_k = K_MAJ;
            end
            default: begin
                w_f = i_state.b ^ i_state.c ^ i_state.d;
                w_k = K_XOR;
            end
        endcase
    end

    always_comb begin
        n_state.a = {i_state.a[26:0], i_state.a[31:27]} + w_f + i_state.e + w_k
                  + i_sched[0];
        n_state.b = i_state.a;
        n_state.c = {i_state.b[1:0], i_state.b[31:2]};
        n_state.d = i_state.c;
        n_state.e = i_state.d;

        // advance the window and append the next schedule word
        w_mix = i_sched[13] ^ i_sched[8] ^ i_sched[2] ^ i_sched[0];
        for (int j = 0; j < SCHED_WORDS - 1; j++) begin
            n_sched[j] = i_sched[j+1];
        end
        n_sched[SCHED_WORDS-1] = {w_mix[30:0], w_mix[31]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
            r_sched <= n_sched;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_sched = r_sched;

endmodule

// ===== sv/sfv_fold.sv =====
// ----------------------------------------------------------------------------
// sfv_fold
// Final stage: add the initial values back and fold the five words to 64 bits.
// ----------------------------------------------------------------------------
module sfv_fold
    import sfv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_state      i_state,
    output logic        o_valid,
    output logic [63:0] o_digest
);

    logic        r_valid;
    logic [63:0] r_digest;
    logic [63:0] n_digest;
    t_word       w_h0;
    t_word       w_h1;
    t_word       w_h2;
    t_word       w_h3;
    t_word       w_h4;
    t_word       w_mid;

    always_comb begin
        w_h0  = IV0 + i_state.a;
        w_h1  = IV1 + i_state.b;
        w_h2  = IV2 + i_state.c;
        w_h3  = IV3 + i_state.d;
        w_h4  = IV4 + i_state.e;
        w_mid = w_h1 ^ w_h2;
        n_digest = {w_h0 ^ w_h4, (w_mid << FOLD_SHIFT) ^ w_h3};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_digest <= n_digest;
        end
    end

    assign o_valid  = r_valid;
    assign o_digest = r_digest;

endmodule

// ===== sv/sha1_fold64_vertex_hash.sv =====
// ----------------------------------------------------------------------------
// sha1_fold64_vertex_hash
// 64-bit folded SHA-1 hash of one 32-byte vertex, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | signals                          | dir | beat
//  ---------+----------------------------------+-----+--------------------
//  input    | i_valid/o_ready, i_word_0..7     | in  | one vertex
//  output   | o_valid/i_ready, o_digest        | out | one 64-bit digest
//
//  One beat enters per cycle while o_ready is high; 80 round stages and one fold stage follow.
//  Throughput is set by the single global advance enable: every stage moves
//  when the output register is empty or being taken.
//  A stall on the output freezes all stages; nothing is dropped or repeated.
//  Synchronous active-low reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module sha1_fold64_vertex_hash
    import sfv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_word_0,
    input  logic [31:0] i_word_1,
    input  logic [31:0] i_word_2,
    input  logic [31:0] i_word_3,
    input  logic [31:0] i_word_4,
    input  logic [31:0] i_word_5,
    input  logic [31:0] i_word_6,
    input  logic [31:0] i_word_7,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_digest
);

    logic                  w_en;
    logic [NUM_ROUNDS:0]   w_valid;
    t_state                w_state [NUM_ROUNDS+1];
    t_sched                w_sched [NUM_ROUNDS+1];

    // advance whenever the output slot is free or being drained
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    assign w_valid[0] = i_valid;
    assign w_state[0] = {IV0, IV1, IV2, IV3, IV4};
    // block layout: vertex words, pad word, zeros, byte count in word 14
    assign w_sched[0] = {t_word'(0), VERTEX_BYTES, {5{t_word'(0)}}, PAD_WORD,
                         i_word_7, i_word_6, i_word_5, i_word_4,
                         i_word_3, i_word_2, i_word_1, i_word_0};

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        sfv_round #(
            .ROUND_IDX (g)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_state (w_state[g]),
            .i_sched (w_sched[g]),
            .o_valid (w_valid[g+1]),
            .o_state (w_state[g+1]),
            .o_sched (w_sched[g+1])
        );
    end

    sfv_fold u_fold (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_valid[NUM_ROUNDS]),
        .i_state  (w_state[NUM_ROUNDS]),
        .o_valid  (o_valid),
        .o_digest (o_digest)
    );

endmodule

// ===== sv/sfv_checker.sv =====
// ----------------------------------------------------------------------------
// sfv_checker
// Port-level checks for the vertex hash pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module sfv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_digest
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_digest))
        else $error("output digest changed while stalled");

    // input backpressure only comes from a blocked output slot
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled without output backpressure");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a new result only shows up after the pipeline advanced
    a_rise_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_ready))
        else $error("output appeared without pipeline advance");

endmodule

bind sha1_fold64_vertex_hash sfv_checker u_checker (.*);
